@@ rtl/nnpol_pkg.sv @@
// ----------------------------------------------------------------------------
// nnpol_pkg
// Shared widths, defaults and controller/datapath bundles for the pairwise
// output layer of the position evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package nnpol_pkg;

  // Default network constants.
  localparam int unsigned CLAMP_MAX_DEF    = 255;
  localparam int unsigned WEIGHT_SCALE_DEF = 64;
  localparam int unsigned OUT_SCALE_DEF    = 400;
  localparam int unsigned NUM_BUCKETS_DEF  = 8;

  // Bucket selection constants.
  localparam int unsigned TOTAL_PIECES = 32;
  localparam int unsigned MIN_PIECES   = 2;
  localparam int unsigned BIAS_REGS    = 8;

  // Field and datapath widths.
  localparam int unsigned WORD_W    = 16;
  localparam int unsigned PIECE_W   = 6;
  localparam int unsigned BUCKET_W  = 3;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned EVAL_W    = 32;
  localparam int unsigned SUM_W     = 64;
  localparam int unsigned HALF_W    = SUM_W / 2;
  localparam int unsigned CLAMP_W   = 8;
  localparam int unsigned PROD_W    = 2 * CLAMP_W;
  localparam int unsigned WPROD_W   = WORD_W + PROD_W + 1;
  localparam int unsigned PAIR_W    = WPROD_W + 1;
  localparam int unsigned SCALE_W   = 11;

  // One input item, as seen by the datapath.
  typedef struct packed {
    logic signed [WORD_W-1:0]  mover_psq_low;
    logic signed [WORD_W-1:0]  mover_extra_low;
    logic signed [WORD_W-1:0]  mover_psq_high;
    logic signed [WORD_W-1:0]  mover_extra_high;
    logic signed [WORD_W-1:0]  other_psq_low;
    logic signed [WORD_W-1:0]  other_extra_low;
    logic signed [WORD_W-1:0]  other_psq_high;
    logic signed [WORD_W-1:0]  other_extra_high;
    logic signed [WORD_W-1:0]  mover_weight;
    logic signed [WORD_W-1:0]  other_weight;
    logic        [PIECE_W-1:0] piece_count;
    logic                      last_pair;
  } nnpol_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the clamped pair values and weights
    logic pick;       // capture the output bucket (first item of a position)
    logic seed;       // seed the running sum with the bucket bias
    logic mul1;       // multiply the clamped halves
    logic mul2;       // apply the weights
    logic pair;       // add the two weighted products
    logic acc;        // add the pair into the running sum
    logic scl_lo;     // scale the low half of the sum
    logic scl_hi;     // scale the high half of the sum
    logic scl_sum;    // combine the scaled halves
    logic div_start;  // launch the divider
    logic emit;       // load the result register
  } nnpol_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
    logic div_busy;
    logic div_done;
  } nnpol_status_t;

endpackage

`default_nettype wire

@@ rtl/nnpol_if.sv @@
// ----------------------------------------------------------------------------
// nnpol_if
// Valid/ready channels of the output layer: item input, result output and
// configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

interface nnpol_item_if;
  import nnpol_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [WORD_W-1:0]  mover_psq_low;
  logic signed [WORD_W-1:0]  mover_extra_low;
  logic signed [WORD_W-1:0]  mover_psq_high;
  logic signed [WORD_W-1:0]  mover_extra_high;
  logic signed [WORD_W-1:0]  other_psq_low;
  logic signed [WORD_W-1:0]  other_extra_low;
  logic signed [WORD_W-1:0]  other_psq_high;
  logic signed [WORD_W-1:0]  other_extra_high;
  logic signed [WORD_W-1:0]  mover_weight;
  logic signed [WORD_W-1:0]  other_weight;
  logic        [PIECE_W-1:0] piece_count;
  logic                      last_pair;

  modport source (
    output valid, mover_psq_low, mover_extra_low, mover_psq_high, mover_extra_high,
           other_psq_low, other_extra_low, other_psq_high, other_extra_high,
           mover_weight, other_weight, piece_count, last_pair,
    input  ready
  );

  modport sink (
    input  valid, mover_psq_low, mover_extra_low, mover_psq_high, mover_extra_high,
           other_psq_low, other_extra_low, other_psq_high, other_extra_high,
           mover_weight, other_weight, piece_count, last_pair,
    output ready
  );
endinterface

interface nnpol_result_if;
  import nnpol_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [EVAL_W-1:0]  evaluation;
  logic        [BUCKET_W-1:0] bucket_used;

  modport source (output valid, evaluation, bucket_used, input ready);
  modport sink   (input  valid, evaluation, bucket_used, output ready);
endinterface

interface nnpol_cfg_if;
  import nnpol_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input  valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/nnpol_div.sv @@
// ----------------------------------------------------------------------------
// nnpol_div
// Division of an unsigned 64-bit dividend by a constant divisor, done as a
// multiplication by the rounded-up reciprocal, one 32 by 32 bit partial
// product per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module nnpol_div import nnpol_pkg::*; #(
  parameter int unsigned DIVISOR = CLAMP_MAX_DEF * CLAMP_MAX_DEF * WEIGHT_SCALE_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [SUM_W-1:0] dividend_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [SUM_W-1:0]      quotient_o
);

  // A dividend at or above 2^31 times the divisor gives a quotient that the
  // 32-bit result saturates anyway, so it is flagged and the quotient forced
  // to all ones. Below that limit the product with the reciprocal, shifted
  // right by SHIFT, is exact: the rounding error of the reciprocal times the
  // dividend stays under one divisor step.
  localparam int unsigned DIV_W  = $clog2(DIVISOR + 1);
  localparam int unsigned SHIFT  = EVAL_W - 1 + 2 * DIV_W;
  localparam int unsigned WIDE_W = 2 * SUM_W;
  localparam int unsigned STEPS  = 4;
  localparam int unsigned CNT_W  = $clog2(STEPS);
  localparam logic [SUM_W-1:0] RECIP =
    SUM_W'(((WIDE_W'(1) << SHIFT) + WIDE_W'(DIVISOR - 1)) / WIDE_W'(DIVISOR));
  localparam logic [SUM_W-1:0] LIMIT = SUM_W'(DIVISOR) << (EVAL_W - 1);

  logic [SUM_W-1:0]  mag_q;
  logic              sat_q;
  logic [WIDE_W-1:0] acc_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q;
  logic [HALF_W-1:0] op_a, op_b;
  logic [SUM_W-1:0]  part;
  logic [WIDE_W-1:0] addend;

  // Operand halves for the current partial product.
  always_comb begin
    op_a = cnt_q[1] ? mag_q[SUM_W-1:HALF_W] : mag_q[HALF_W-1:0];
    op_b = cnt_q[0] ? RECIP[SUM_W-1:HALF_W] : RECIP[HALF_W-1:0];
  end

  assign part = op_a * op_b;

  // Place the partial product at its weight in the wide sum.
  always_comb begin
    case (cnt_q)
      2'd0:    addend = {{SUM_W{1'b0}}, part};
      2'd3:    addend = {part, {SUM_W{1'b0}}};
      default: addend = {{HALF_W{1'b0}}, part, {HALF_W{1'b0}}};
    endcase
  end

  // Step counter and handshake flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Captured dividend, saturation flag and the accumulated product.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= dividend_i;
      sat_q <= (dividend_i >= LIMIT);
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + addend;
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = sat_q ? '1 : SUM_W'(acc_q >> SHIFT);

endmodule

`default_nettype wire

@@ rtl/nnpol_dp.sv @@
// ----------------------------------------------------------------------------
// nnpol_dp
// Datapath of the output layer: bias registers, clamp, products, the 64-bit
// running sum, output scaling, division and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module nnpol_dp import nnpol_pkg::*; #(
  parameter int unsigned CLAMP_MAX    = CLAMP_MAX_DEF,
  parameter int unsigned WEIGHT_SCALE = WEIGHT_SCALE_DEF,
  parameter int unsigned OUT_SCALE    = OUT_SCALE_DEF,
  parameter int unsigned NUM_BUCKETS  = NUM_BUCKETS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire nnpol_cmd_t           cmd_i,
  output nnpol_status_t             status_o,
  input  wire nnpol_item_t          item_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [WORD_W-1:0]    cfg_data_i,
  output logic signed [EVAL_W-1:0]  evaluation_o,
  output logic [BUCKET_W-1:0]       bucket_used_o
);

  localparam int unsigned DIVISOR     = CLAMP_MAX * CLAMP_MAX * WEIGHT_SCALE;
  localparam int unsigned BUCKET_SPAN = (TOTAL_PIECES + NUM_BUCKETS - 1) / NUM_BUCKETS;
  localparam int unsigned SEED_W      = CLAMP_W + 1 + WORD_W;
  localparam int unsigned LO_W        = HALF_W + SCALE_W;
  localparam logic [CLAMP_W-1:0] CLAMP_C = CLAMP_W'(CLAMP_MAX);
  localparam logic [SCALE_W-1:0] SCALE_C = SCALE_W'(OUT_SCALE);
  localparam logic [SUM_W-1:0]   POS_LIM = SUM_W'(64'h0000_0000_7FFF_FFFF);
  localparam logic [SUM_W-1:0]   NEG_LIM = SUM_W'(64'h0000_0000_8000_0000);

  // Sum of two words clamped to 0..CLAMP_MAX.
  function automatic logic [CLAMP_W-1:0] clamp_pair(input logic signed [WORD_W-1:0] a,
                                                    input logic signed [WORD_W-1:0] b);
    logic signed [WORD_W:0] s;
    s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
    if (s[WORD_W]) begin
      return '0;
    end else if (s > $signed({1'b0, WORD_W'(CLAMP_MAX)})) begin
      return CLAMP_C;
    end else begin
      return s[CLAMP_W-1:0];
    end
  endfunction

  logic signed [WORD_W-1:0]  bias_q [BIAS_REGS];
  logic [CLAMP_W-1:0]        m0_q, m1_q, o0_q, o1_q;
  logic signed [WORD_W-1:0]  mw_q, ow_q;
  logic                      last_q;
  logic [BUCKET_W-1:0]       bucket_q, bucket_pick;
  logic [PROD_W-1:0]         pm_q, po_q;
  logic signed [WPROD_W-1:0] wm_q, wo_q;
  logic signed [PAIR_W-1:0]  pair_q;
  logic [SUM_W-1:0]          sum_q;
  logic [LO_W-1:0]           plo_q;
  logic [HALF_W-1:0]         phi_q;
  logic [SUM_W-1:0]          t_q;
  logic                      neg_q;
  logic signed [SEED_W-1:0]  seed;
  logic [SUM_W-1:0]          magnitude;
  logic [SUM_W-1:0]          quotient;
  logic                      div_busy, div_done;
  logic signed [EVAL_W-1:0]  eval_d;
  logic signed [EVAL_W-1:0]  eval_q;
  logic [BUCKET_W-1:0]       bucket_out_q;
  logic [LO_W-1:0]           hi_prod;

  // Bias register writes; indexes past the bias bank are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BIAS_REGS; i++) begin
        bias_q[i] <= '0;
      end
    end else if (cfg_we_i && (cfg_index_i < CFG_IDX_W'(BIAS_REGS))) begin
      bias_q[cfg_index_i[BUCKET_W-1:0]] <= cfg_data_i;
    end
  end

  // Bucket choice: count the bucket boundaries the piece count has passed.
  always_comb begin
    bucket_pick = '0;
    if (item_i.piece_count >= PIECE_W'(MIN_PIECES)) begin
      for (int k = 1; k < NUM_BUCKETS; k++) begin
        if (({1'b0, item_i.piece_count} - (PIECE_W + 1)'(MIN_PIECES)) >=
            (PIECE_W + 1)'(k * BUCKET_SPAN)) begin
          bucket_pick = bucket_pick + BUCKET_W'(1);
        end
      end
    end
  end

  // Bias seed of the running sum.
  assign seed = $signed({1'b0, CLAMP_C}) * bias_q[bucket_q];

  // Upper half of the scaled sum; only its low word survives the wrap.
  assign hi_prod = sum_q[SUM_W-1:HALF_W] * SCALE_C;

  // Magnitude of the scaled sum for the unsigned divider.
  assign magnitude = t_q[SUM_W-1] ? (~t_q + SUM_W'(1)) : t_q;

  // Saturate the signed quotient to 32 bits.
  always_comb begin
    if (neg_q) begin
      eval_d = (quotient > NEG_LIM) ? $signed(32'h8000_0000) :
                                      $signed(~quotient[EVAL_W-1:0] + EVAL_W'(1));
    end else begin
      eval_d = (quotient > POS_LIM) ? $signed(32'h7FFF_FFFF) : $signed(quotient[EVAL_W-1:0]);
    end
  end

  // Bucket register, chosen on the first item of a position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_q <= '0;
    end else if (cmd_i.pick) begin
      bucket_q <= bucket_pick;
    end
  end

  // Arithmetic stages, each stepped by its own command.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      m0_q   <= clamp_pair(item_i.mover_psq_low,  item_i.mover_extra_low);
      m1_q   <= clamp_pair(item_i.mover_psq_high, item_i.mover_extra_high);
      o0_q   <= clamp_pair(item_i.other_psq_low,  item_i.other_extra_low);
      o1_q   <= clamp_pair(item_i.other_psq_high, item_i.other_extra_high);
      mw_q   <= item_i.mover_weight;
      ow_q   <= item_i.other_weight;
      last_q <= item_i.last_pair;
    end
    if (cmd_i.mul1) begin
      pm_q <= m0_q * m1_q;
      po_q <= o0_q * o1_q;
    end
    if (cmd_i.seed) begin
      sum_q <= {{(SUM_W - SEED_W){seed[SEED_W-1]}}, seed};
    end
    if (cmd_i.mul2) begin
      wm_q <= mw_q * $signed({1'b0, pm_q});
      wo_q <= ow_q * $signed({1'b0, po_q});
    end
    if (cmd_i.pair) begin
      pair_q <= {wm_q[WPROD_W-1], wm_q} + {wo_q[WPROD_W-1], wo_q};
    end
    if (cmd_i.acc) begin
      sum_q <= sum_q + {{(SUM_W - PAIR_W){pair_q[PAIR_W-1]}}, pair_q};
    end
    if (cmd_i.scl_lo) begin
      plo_q <= sum_q[HALF_W-1:0] * SCALE_C;
    end
    if (cmd_i.scl_hi) begin
      phi_q <= hi_prod[HALF_W-1:0];
    end
    if (cmd_i.scl_sum) begin
      t_q <= {phi_q, {HALF_W{1'b0}}} + {{(SUM_W - LO_W){1'b0}}, plo_q};
    end
    if (cmd_i.div_start) begin
      neg_q <= t_q[SUM_W-1];
    end
    if (cmd_i.emit) begin
      eval_q       <= eval_d;
      bucket_out_q <= bucket_q;
    end
  end

  nnpol_div #(
    .DIVISOR (DIVISOR)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (magnitude),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign status_o.last     = last_q;
  assign status_o.div_busy = div_busy;
  assign status_o.div_done = div_done;
  assign evaluation_o      = eval_q;
  assign bucket_used_o     = bucket_out_q;

endmodule

`default_nettype wire

@@ rtl/nnpol_ctrl.sv @@
// ----------------------------------------------------------------------------
// nnpol_ctrl
// Sequencer of the output layer: steps one item through the datapath and,
// on the last item of a position, through scaling, division and emission.
// ----------------------------------------------------------------------------
`default_nettype none

module nnpol_ctrl import nnpol_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          out_ready_i,
  output logic               out_valid_o,
  output nnpol_cmd_t         cmd_o,
  input  wire nnpol_status_t status_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_PAIR,
    ST_ACC,
    ST_SCL_LO,
    ST_SCL_HI,
    ST_SCL_SUM,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT
  } state_e;

  state_e state_q;
  logic   in_pos_q;
  logic   first_q;
  logic   out_valid_q;
  logic   emit_ok;

  // The result register is free when empty or drained this cycle.
  assign emit_ok = !out_valid_q || out_ready_i;

  // Command decode.
  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.pick      = (state_q == ST_IDLE) && in_valid_i && !in_pos_q;
    cmd_o.mul1      = (state_q == ST_MUL1);
    cmd_o.seed      = (state_q == ST_MUL1) && first_q;
    cmd_o.mul2      = (state_q == ST_MUL2);
    cmd_o.pair      = (state_q == ST_PAIR);
    cmd_o.acc       = (state_q == ST_ACC);
    cmd_o.scl_lo    = (state_q == ST_SCL_LO);
    cmd_o.scl_hi    = (state_q == ST_SCL_HI);
    cmd_o.scl_sum   = (state_q == ST_SCL_SUM);
    cmd_o.div_start = (state_q == ST_DIV_START);
    cmd_o.emit      = (state_q == ST_EMIT) && emit_ok;
  end

  // State and registered flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_pos_q    <= 1'b0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // The result register fills on emit and drains on a result handshake.
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            first_q  <= !in_pos_q;
            in_pos_q <= 1'b1;
            state_q  <= ST_MUL1;
          end
        end
        ST_MUL1:      state_q <= ST_MUL2;
        ST_MUL2:      state_q <= ST_PAIR;
        ST_PAIR:      state_q <= ST_ACC;
        ST_ACC:       state_q <= status_i.last ? ST_SCL_LO : ST_IDLE;
        ST_SCL_LO:    state_q <= ST_SCL_HI;
        ST_SCL_HI:    state_q <= ST_SCL_SUM;
        ST_SCL_SUM:   state_q <= ST_DIV_START;
        ST_DIV_START: state_q <= ST_DIV_WAIT;
        ST_DIV_WAIT: begin
          if (status_i.div_done) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_ok) begin
            in_pos_q <= 1'b0;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/nnue_pairwise_output_layer_unit.sv @@
// ----------------------------------------------------------------------------
// nnue_pairwise_output_layer_unit
// Pairwise clipped-ReLU output layer with output buckets: accumulates one
// weighted pair product per request and emits a scaled, saturated evaluation
// at the end of each position.
//
//   channel   dir   role
//   item_i    in    accumulator words, weights, piece count, last flag
//   result_o  out   evaluation and bucket used, one per position
//   cfg_i     in    bias register writes, index 0..7, always ready
//
// A request that is not the last of its position passes through accept,
// clamp product, weight, pair add and sum update, all through one sequencer.
// The last request adds scaling of the low half, the high half and their sum,
// a divider launch, a wait in which the divider multiplies by the reciprocal
// of the divisor in four 32-bit partial products, and the emit step.
// The result waits in an output register; the next request is accepted
// while it waits, and only a further result stalls on it.
// Reset clears the sequencer, the bias registers and the chosen bucket.
// ----------------------------------------------------------------------------
`default_nettype none

module nnue_pairwise_output_layer_unit import nnpol_pkg::*; #(
  parameter int unsigned CLAMP_MAX    = CLAMP_MAX_DEF,
  parameter int unsigned WEIGHT_SCALE = WEIGHT_SCALE_DEF,
  parameter int unsigned OUT_SCALE    = OUT_SCALE_DEF,
  parameter int unsigned NUM_BUCKETS  = NUM_BUCKETS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  nnpol_item_if.sink      item_i,
  nnpol_result_if.source  result_o,
  nnpol_cfg_if.sink       cfg_i
);

  nnpol_cmd_t    cmd;
  nnpol_status_t status;
  nnpol_item_t   item;

  // Gather the item fields for the datapath.
  assign item.mover_psq_low    = item_i.mover_psq_low;
  assign item.mover_extra_low  = item_i.mover_extra_low;
  assign item.mover_psq_high   = item_i.mover_psq_high;
  assign item.mover_extra_high = item_i.mover_extra_high;
  assign item.other_psq_low    = item_i.other_psq_low;
  assign item.other_extra_low  = item_i.other_extra_low;
  assign item.other_psq_high   = item_i.other_psq_high;
  assign item.other_extra_high = item_i.other_extra_high;
  assign item.mover_weight     = item_i.mover_weight;
  assign item.other_weight     = item_i.other_weight;
  assign item.piece_count      = item_i.piece_count;
  assign item.last_pair        = item_i.last_pair;

  // Configuration writes are always accepted.
  assign cfg_i.ready = 1'b1;

  nnpol_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_ready_i (result_o.ready),
    .out_valid_o (result_o.valid),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  nnpol_dp #(
    .CLAMP_MAX    (CLAMP_MAX),
    .WEIGHT_SCALE (WEIGHT_SCALE),
    .OUT_SCALE    (OUT_SCALE),
    .NUM_BUCKETS  (NUM_BUCKETS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .item_i        (item),
    .cfg_we_i      (cfg_i.valid),
    .cfg_index_i   (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .evaluation_o  (result_o.evaluation),
    .bucket_used_o (result_o.bucket_used)
  );

  // Datapath commands are mutually exclusive, but for the seed during the
  // first product stage and the bucket pick that comes with a load.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.mul1, cmd.mul2, cmd.pair, cmd.acc, cmd.scl_lo,
              cmd.scl_hi, cmd.scl_sum, cmd.div_start, cmd.emit}))
    else $error("overlapping datapath commands");

  // No request is taken while the divider is still working.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready) |-> !status.div_busy)
    else $error("request accepted during division");

  // A new result never overwrites one that is still held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!result_o.valid || result_o.ready))
    else $error("result register overwritten");

  // Launching the divider makes it busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |=> status.div_busy)
    else $error("divider did not start");

endmodule

`default_nettype wire
